FILE: rtl/pmv_pkg.sv
// ----------------------------------------------------------------------------
// pmv_pkg
// Shared types, constants and helpers of the pad pedestal statistics block.
// ----------------------------------------------------------------------------
package pmv_pkg;

  localparam int SECTORS_DEF = 6;
  localparam int ROWS_DEF    = 90;
  localparam int COLS_DEF    = 92;

  localparam int CNT_W    = 24;
  localparam int MEAN_W   = 26;
  localparam int SPREAD_W = 40;
  localparam int SIGMA_W  = 20;
  localparam int CFG_W    = 16;

  localparam logic [CNT_W-1:0]   CNT_MAX       = '1;
  localparam logic [SIGMA_W-1:0] SIGMA_ONE_HIT = SIGMA_W'(3);

  // result status codes
  localparam logic [2:0] ST_DISABLED = 3'd0;
  localparam logic [2:0] ST_BAD_PAD  = 3'd1;
  localparam logic [2:0] ST_ACCEPTED = 3'd2;
  localparam logic [2:0] ST_RUNAWAY  = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  localparam logic OP_HIT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    CFG_SECTOR_ENABLE = 3'd0,
    CFG_SIGMA_MULT    = 3'd1,
    CFG_EPSILON       = 3'd2,
    CFG_MIN_DISTANCE  = 3'd3,
    CFG_MIN_COUNT     = 3'd4
  } pmv_cfg_e;

  typedef struct packed {
    logic [CNT_W-1:0]    acc;
    logic [CNT_W-1:0]    tot;
    logic [CNT_W-1:0]    run;
    logic [MEAN_W-1:0]   mean;
    logic [SPREAD_W-1:0] spread;
  } pmv_entry_t;

  localparam int ENTRY_W = $bits(pmv_entry_t);

  // control to and status from the shared divide / square-root unit
  typedef struct packed {
    logic start;
    logic sqrt;
  } pmv_dreq_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pmv_dstat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
  endfunction

endpackage

FILE: rtl/pmv_if.sv
// ----------------------------------------------------------------------------
// pmv_if
// Valid/ready channels for hit and read requests and for their results.
// ----------------------------------------------------------------------------
interface pmv_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [2:0] sector;
  logic [6:0] pad_row;
  logic [6:0] pad_col;
  logic [9:0] charge;

  modport source (output valid, operation, sector, pad_row, pad_col, charge,
                  input ready);
  modport sink   (input valid, operation, sector, pad_row, pad_col, charge,
                  output ready);
endinterface

interface pmv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [25:0] mean_value;
  logic [19:0] sigma_value;
  logic [23:0] accepted_count;
  logic [23:0] total_count;
  logic [23:0] runaway_count;

  modport source (output valid, status, mean_value, sigma_value, accepted_count,
                  total_count, runaway_count, input ready);
  modport sink   (input valid, status, mean_value, sigma_value, accepted_count,
                  total_count, runaway_count, output ready);
endinterface

FILE: rtl/pad_pedestal_mean_variance_core.sv
// ----------------------------------------------------------------------------
// pad_pedestal_mean_variance_core
// Per-pad running mean and spread with sigma clipping, kept in one RAM.
// ----------------------------------------------------------------------------
// A disabled sector or bad pad goes straight to the result; a read takes a
// square root, a runaway hit adds the threshold test, a first hit on a pad a
// mean division and a later hit a spread division (one-bit-per-cycle unit).
// One transaction in flight; the next is taken the cycle after the result
// is registered. Reset: a clearing pass then writes SECTORS*ROWS*COLS
// entries (49680 at defaults), one per cycle, before any transaction.
module pad_pedestal_mean_variance_core
  import pmv_pkg::*;
#(
  parameter int SECTORS = SECTORS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int COLS    = COLS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  pmv_in_if.sink           in_i,
  pmv_out_if.source        out_o
);
  localparam int PADS  = SECTORS * ROWS * COLS;
  localparam int IDX_W = (PADS > 1) ? $clog2(PADS) : 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_IDX1, S_IDX2, S_RD, S_RDW, S_MULA, S_MULB, S_SQS, S_SQW,
    S_THR, S_DEC, S_DQW, S_QQ, S_MULC, S_MULD, S_DSS, S_DSW, S_WR, S_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [5:0]  en_q;
  logic [7:0]  kmul_q, mincnt_q;
  logic [15:0] eps_q;
  logic [9:0]  mindist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= '0;
      kmul_q    <= 8'd96;
      eps_q     <= 16'd66;
      mindist_q <= 10'd2;
      mincnt_q  <= 8'd5;
    end else if (cfg_we_i) begin
      case (pmv_cfg_e'(cfg_index_i))
        CFG_SECTOR_ENABLE: en_q      <= cfg_data_i[5:0];
        CFG_SIGMA_MULT:    kmul_q    <= cfg_data_i[7:0];
        CFG_EPSILON:       eps_q     <= cfg_data_i[15:0];
        CFG_MIN_DISTANCE:  mindist_q <= cfg_data_i[9:0];
        CFG_MIN_COUNT:     mincnt_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // item and working registers
  logic             op_q;
  logic [2:0]       sec_q;
  logic [6:0]       row_q, col_q;
  logic [9:0]       chg_q;
  logic [IDX_W-1:0] t_q, idx_q, clr_q;
  pmv_entry_t       ent_q;
  logic [63:0]      prod_q;
  logic [31:0]      sig_q;
  logic [44:0]      thr_q;
  logic [25:0]      dist_q, q_q;
  logic             up_q;
  logic [51:0]      qq_q;
  logic [2:0]       status_q;
  logic [19:0]      sigma_q;
  logic             zero_q;

  // output register
  logic        ov_q;
  logic [2:0]  ost_q;
  logic [25:0] omean_q;
  logic [19:0] osig_q;
  logic [23:0] oacc_q, otot_q, orun_q;

  // RAM
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_addr;
  pmv_entry_t       ram_rdata;

  pmv_ram #(.WIDTH(ENTRY_W), .DEPTH(PADS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i((state_q == S_CLEAR) ? ENTRY_W'(0) : ENTRY_W'(ent_q)),
    .rdata_o(ram_rdata)
  );

  assign ram_we   = (state_q == S_CLEAR) || (state_q == S_WR);
  assign ram_re   = (state_q == S_RD);
  assign ram_addr = (state_q == S_CLEAR) ? clr_q : idx_q;

  // divide / square-root unit
  pmv_dreq_t   dreq;
  pmv_dstat_t  dstat;
  logic [63:0] dnum, dres;
  logic [24:0] dden;

  // combinational helpers
  logic [7:0]  en_ext;
  logic        sec_bad, hit_off, pad_bad;
  logic [25:0] xval;
  logic        outlier;
  logic [26:0] m_sum;
  logic [25:0] m_new;
  logic [40:0] s_sum;
  logic [36:0] qq_rnd;
  logic [25:0] q_cl;

  assign dden = {1'b0, ent_q.acc} + 25'd1;

  always_comb begin
    dreq.start = 1'b0;
    dreq.sqrt  = 1'b0;
    dnum       = prod_q;
    case (state_q)
      S_SQS: begin
        dreq.start = 1'b1;
        dreq.sqrt  = 1'b1;
      end
      S_DEC: begin
        // only an accepted hit needs the mean step
        dreq.start = !outlier;
        dnum       = 64'(dist_q) + 64'(dden[24:1]);
      end
      S_DSS: begin
        dreq.start = 1'b1;
        dnum       = prod_q + 64'(dden[24:1]);
      end
      default: ;
    endcase
  end

  pmv_divsqrt u_divsqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .num_i (dnum),
    .den_i (dden),
    .stat_o(dstat),
    .res_o (dres)
  );

  assign en_ext  = {2'b00, en_q};
  assign sec_bad = ({1'b0, in_i.sector} >= 4'(SECTORS));
  assign hit_off = sec_bad || (in_i.sector >= 3'd6) || !en_ext[in_i.sector];
  assign pad_bad = ({1'b0, in_i.pad_row} >= 8'(ROWS)) ||
                   ({1'b0, in_i.pad_col} >= 8'(COLS));
  assign xval    = {chg_q, 16'b0};
  assign outlier = (ent_q.acc > {16'b0, mincnt_q}) &&
                   ({19'b0, dist_q} >= thr_q) &&
                   (dist_q > {mindist_q, 16'b0});
  assign q_cl    = (dres > 64'(dist_q)) ? dist_q : dres[25:0];
  assign m_sum   = up_q ? {1'b0, ent_q.mean} + {1'b0, q_q}
                        : {1'b0, ent_q.mean} - {1'b0, q_q};
  assign m_new   = m_sum[26] && up_q ? '1 : m_sum[25:0];
  assign qq_rnd  = 37'((53'(qq_q) + 53'h8000) >> 16);
  assign s_sum   = {1'b0, dres[39:0]} + 41'(qq_rnd);

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == IDX_W'(PADS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_i.valid) begin
            if ((in_i.operation == OP_READ) ? sec_bad : hit_off) begin
              state_q <= S_DONE;
            end else if (pad_bad) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_IDX1;
            end
          end
        end
        S_IDX1: state_q <= S_IDX2;
        S_IDX2: state_q <= S_RD;
        S_RD:   state_q <= S_RDW;
        S_RDW:  state_q <= S_MULA;
        S_MULA: state_q <= S_MULB;
        S_MULB: state_q <= S_SQS;
        S_SQS:  state_q <= S_SQW;
        S_SQW:  if (dstat.done) state_q <= (op_q == OP_READ) ? S_DONE : S_THR;
        S_THR:  state_q <= S_DEC;
        S_DEC:  state_q <= outlier ? S_WR : S_DQW;
        S_DQW:  if (dstat.done) state_q <= S_QQ;
        S_QQ:   state_q <= (ent_q.acc == '0) ? S_WR : S_MULC;
        S_MULC: state_q <= S_MULD;
        S_MULD: state_q <= S_DSS;
        S_DSS:  state_q <= S_DSW;
        S_DSW:  if (dstat.done) state_q <= S_WR;
        S_WR:   state_q <= S_DONE;
        S_DONE: begin
          // hold until the output register is free
          if (!ov_q || out_o.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if ((state_q == S_DONE) && (!ov_q || out_o.ready)) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q    <= in_i.operation;
        sec_q   <= in_i.sector;
        row_q   <= in_i.pad_row;
        col_q   <= in_i.pad_col;
        chg_q   <= in_i.charge;
        sigma_q <= '0;
        zero_q  <= 1'b1;
        if ((in_i.operation == OP_READ) ? sec_bad : hit_off) status_q <= ST_DISABLED;
        else status_q <= ST_BAD_PAD;
      end
      S_IDX1: t_q   <= IDX_W'(sec_q) * IDX_W'(COLS) + IDX_W'(col_q);
      S_IDX2: idx_q <= t_q * IDX_W'(ROWS) + IDX_W'(row_q);
      S_RDW: begin
        ent_q  <= ram_rdata;
        zero_q <= 1'b0;
      end
      S_MULA: prod_q <= 64'(ent_q.spread[19:0] * ent_q.acc);
      S_MULB: prod_q <= prod_q + (64'(ent_q.spread[39:20] * ent_q.acc) << 20);
      S_SQW: begin
        if (dstat.done) begin
          sig_q    <= dres[31:0];
          status_q <= ST_READ;
          if (ent_q.tot == CNT_W'(1)) sigma_q <= SIGMA_ONE_HIT;
          else if (dres[31:20] != '0) sigma_q <= '1;
          else sigma_q <= dres[19:0];
        end
      end
      S_THR: begin
        sigma_q <= '0;
        thr_q   <= (45'(kmul_q * sig_q) << 4) + 45'(eps_q);
        dist_q  <= (ent_q.mean > xval) ? ent_q.mean - xval : xval - ent_q.mean;
        up_q    <= (xval >= ent_q.mean);
      end
      S_DEC: begin
        if (outlier) begin
          status_q  <= ST_RUNAWAY;
          ent_q.run <= sat_inc(ent_q.run);
          ent_q.tot <= sat_inc(ent_q.tot);
        end
      end
      S_DQW: if (dstat.done) q_q <= q_cl;
      S_QQ: begin
        qq_q       <= q_q * q_q;
        ent_q.mean <= m_new;
        status_q   <= ST_ACCEPTED;
        if (ent_q.acc == '0) begin
          ent_q.spread <= '0;
          ent_q.acc    <= sat_inc(ent_q.acc);
          ent_q.tot    <= sat_inc(ent_q.tot);
        end
      end
      S_MULC: prod_q <= 64'(ent_q.spread[19:0] * (ent_q.acc - CNT_W'(1)));
      S_MULD: prod_q <= prod_q +
                        ({64'(ent_q.spread[39:20] * (ent_q.acc - CNT_W'(1)))} << 20);
      S_DSW: begin
        if (dstat.done) begin
          ent_q.spread <= s_sum[40] ? '1 : s_sum[39:0];
          ent_q.acc    <= sat_inc(ent_q.acc);
          ent_q.tot    <= sat_inc(ent_q.tot);
        end
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ost_q   <= status_q;
          osig_q  <= sigma_q;
          omean_q <= zero_q ? '0 : ent_q.mean;
          oacc_q  <= zero_q ? '0 : ent_q.acc;
          otot_q  <= zero_q ? '0 : ent_q.tot;
          orun_q  <= zero_q ? '0 : ent_q.run;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid          = ov_q;
  assign out_o.status         = ost_q;
  assign out_o.mean_value     = omean_q;
  assign out_o.sigma_value    = osig_q;
  assign out_o.accepted_count = oacc_q;
  assign out_o.total_count    = otot_q;
  assign out_o.runaway_count  = orun_q;

  // assertions
  a_ram_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR) || (state_q == S_WR))
    else $error("RAM written outside clear or write-back");

  a_sigma_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != ST_READ) |-> out_o.sigma_value == '0)
    else $error("sigma nonzero on a hit reply");

  a_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !dstat.busy)
    else $error("divide/sqrt unit started while busy");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second transaction taken while one is in flight");
endmodule

FILE: rtl/pmv_ram.sv
// ----------------------------------------------------------------------------
// pmv_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[addr_i];
  end
endmodule

FILE: rtl/pmv_divsqrt.sv
// ----------------------------------------------------------------------------
// pmv_divsqrt
// Shared iterative unit: 64-bit by 25-bit division or 64-bit integer square
// root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pmv_divsqrt
  import pmv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pmv_dreq_t   req_i,
  input  logic [63:0] num_i,
  input  logic [24:0] den_i,
  output pmv_dstat_t  stat_o,
  output logic [63:0] res_o
);
  logic        busy_q, done_q, sqrt_q;
  logic [5:0]  cnt_q;
  logic [63:0] acc_q, res_q;
  logic [34:0] rem_q;
  logic [24:0] den_q;

  logic [34:0] rem_sh, trial;
  logic        take;

  always_comb begin
    if (sqrt_q) begin
      rem_sh = {rem_q[32:0], acc_q[63:62]};
      trial  = {1'b0, res_q[31:0], 2'b01};
    end else begin
      rem_sh = {rem_q[33:0], acc_q[63]};
      trial  = {10'b0, den_q};
    end
    take = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        sqrt_q <= req_i.sqrt;
        cnt_q  <= req_i.sqrt ? 6'd31 : 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      acc_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      res_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? rem_sh - trial : rem_sh;
      res_q <= {res_q[62:0], take};
      acc_q <= sqrt_q ? {acc_q[61:0], 2'b00} : {acc_q[62:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = res_q;
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pad pedestal statistics core: a clocked driver
// feeds hit and read transactions from a queue, a predictor keeps its own copy
// of every pad entry, and a monitor compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import pmv_pkg::*;

  localparam int NPADS = SECTORS_DEF * ROWS_DEF * COLS_DEF;

  typedef struct packed {
    logic       op;
    logic [2:0] sec;
    logic [6:0] row;
    logic [6:0] col;
    logic [9:0] chg;
  } pad_req_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [25:0] mean;
    logic [19:0] sig;
    logic [23:0] acc;
    logic [23:0] tot;
    logic [23:0] run;
  } pad_res_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [2:0]       cfg_idx;
  logic [CFG_W-1:0] cfg_dat;

  pmv_in_if  in_if ();
  pmv_out_if out_if ();

  pad_pedestal_mean_variance_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_idx),
    .cfg_data_i (cfg_dat),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // predictor copy of the pad store and registers
  bit [23:0] acc_st [NPADS];
  bit [23:0] tot_st [NPADS];
  bit [23:0] run_st [NPADS];
  bit [25:0] mean_st [NPADS];
  bit [39:0] spread_st [NPADS];
  bit [5:0]  en_r;
  bit [7:0]  kmul_r;
  bit [15:0] eps_r;
  bit [9:0]  mind_r;
  bit [7:0]  minc_r;

  pad_req_t pending_q[$];
  pad_res_t expected_q[$];
  int       send_idle;
  int       recv_stall;
  logic     hold_rx;
  logic     pressure_go;
  int       errors;
  int       n_results;
  int       n_runaway;
  int       n_accepted;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit [63:0] isqrt(input bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [23:0] cnt_inc(input bit [23:0] c);
    return (c == 24'hFFFFFF) ? c : c + 24'd1;
  endfunction

  // advance the pad store by one transaction and return its result
  function automatic pad_res_t pad_update(input pad_req_t r);
    pad_res_t  o;
    int        ix;
    bit [63:0] n, m, x, dst_v, sig8, thr, dv, q, s;
    bit        outl;
    o = '0;
    if (r.sec >= SECTORS_DEF) return o;
    if (r.op == OP_HIT && !en_r[r.sec]) return o;
    if (r.row >= ROWS_DEF || r.col >= COLS_DEF) begin
      o.st = ST_BAD_PAD;
      return o;
    end
    ix = (int'(r.sec) * COLS_DEF + int'(r.col)) * ROWS_DEF + int'(r.row);
    if (r.op == OP_READ) begin
      o.st = ST_READ;
      s = isqrt(64'(spread_st[ix]) * 64'(acc_st[ix]));
      if (s > 64'hFFFFF) s = 64'hFFFFF;
      if (tot_st[ix] == 24'd1) s = 64'(SIGMA_ONE_HIT);
      o.sig = s[19:0];
    end else begin
      n = 64'(acc_st[ix]);
      m = 64'(mean_st[ix]);
      x = 64'(r.chg) << 16;
      dst_v = (m > x) ? m - x : x - m;
      sig8 = isqrt(64'(spread_st[ix]) * n);
      thr = ((64'(kmul_r) * sig8) << 4) + 64'(eps_r);
      outl = n > 64'(minc_r) && dst_v >= thr && dst_v > (64'(mind_r) << 16);
      if (outl) begin
        o.st = ST_RUNAWAY;
        run_st[ix] = cnt_inc(run_st[ix]);
      end else begin
        dv = n + 1;
        q = (dst_v + dv / 2) / dv;
        if (q > dst_v) q = dst_v;
        m = (x >= m) ? m + q : m - q;
        if (m > 64'h3FFFFFF) m = 64'h3FFFFFF;
        mean_st[ix] = m[25:0];
        if (n == 0) begin
          s = 0;
        end else begin
          s = (64'(spread_st[ix]) * (n - 1) + dv / 2) / dv;
          s += (q * q + (64'd1 << 15)) >> 16;
          if (s > 64'hFF_FFFF_FFFF) s = 64'hFF_FFFF_FFFF;
        end
        spread_st[ix] = s[39:0];
        acc_st[ix] = cnt_inc(acc_st[ix]);
        o.st = ST_ACCEPTED;
      end
      tot_st[ix] = cnt_inc(tot_st[ix]);
    end
    o.mean = mean_st[ix];
    o.acc = acc_st[ix];
    o.tot = tot_st[ix];
    o.run = run_st[ix];
    return o;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  // driver: one transaction presented at a time, held until ready
  always @(posedge clk_i) begin : drive
    bit took;
    took = in_if.valid && in_if.ready;
    if (took) expected_q.push_back(pad_update(pending_q.pop_front()));
    if (!in_if.valid || took) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_if.valid     <= 1'b1;
        in_if.operation <= pending_q[0].op;
        in_if.sector    <= pending_q[0].sec;
        in_if.pad_row   <= pending_q[0].row;
        in_if.pad_col   <= pending_q[0].col;
        in_if.charge    <= pending_q[0].chg;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor: compare against the oldest expectation
  always @(posedge clk_i) begin : watch
    pad_res_t e;
    if (out_if.valid && out_if.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report("unexpected result", out_if.status, 0);
      end else begin
        e = expected_q.pop_front();
        if (e.st == ST_RUNAWAY) n_runaway++;
        if (e.st == ST_ACCEPTED) n_accepted++;
        if (out_if.status !== e.st) report("status", out_if.status, e.st);
        if (out_if.mean_value !== e.mean) report("mean", out_if.mean_value, e.mean);
        if (out_if.sigma_value !== e.sig) report("sigma", out_if.sigma_value, e.sig);
        if (out_if.accepted_count !== e.acc) report("accepted", out_if.accepted_count, e.acc);
        if (out_if.total_count !== e.tot) report("total", out_if.total_count, e.tot);
        if (out_if.runaway_count !== e.run) report("runaway", out_if.runaway_count, e.run);
      end
    end
    if (rst_ni) out_if.ready <= !hold_rx && ($urandom_range(99) >= recv_stall);
  end

  // long receiver hold-off so the core backs up into its input
  initial begin
    hold_rx = 1'b0;
    wait (pressure_go === 1'b1);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (800) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  task automatic cfg_write(input pmv_cfg_e ix, input logic [15:0] v);
    @(posedge clk_i);
    cfg_we  <= 1'b1;
    cfg_idx <= ix;
    cfg_dat <= v;
    case (ix)
      CFG_SECTOR_ENABLE: en_r   = v[5:0];
      CFG_SIGMA_MULT:    kmul_r = v[7:0];
      CFG_EPSILON:       eps_r  = v;
      CFG_MIN_DISTANCE:  mind_r = v[9:0];
      CFG_MIN_COUNT:     minc_r = v[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [5:0] en, input logic [7:0] k, input logic [15:0] ep,
                         input logic [9:0] md, input logic [7:0] mc);
    cfg_write(CFG_SECTOR_ENABLE, 16'(en));
    cfg_write(CFG_SIGMA_MULT, 16'(k));
    cfg_write(CFG_EPSILON, ep);
    cfg_write(CFG_MIN_DISTANCE, 16'(md));
    cfg_write(CFG_MIN_COUNT, 16'(mc));
  endtask

  task automatic push(input logic op, input int sec, input int row, input int col,
                      input int chg);
    pad_req_t r;
    r.op = op;
    r.sec = 3'(sec);
    r.row = 7'(row);
    r.col = 7'(col);
    r.chg = 10'(chg);
    pending_q.push_back(r);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk_i);
    // a dropped item may still be in flight
    repeat (250) @(posedge clk_i);
  endtask

  // random phase: a small pool of pads hit around a pedestal, with outliers, reads and random requests
  task automatic random_phase(input int count);
    int pr[6], pc[6], ps[6], pb[6];
    int k, j, c;
    for (j = 0; j < 6; j++) begin
      ps[j] = $urandom_range(SECTORS_DEF - 1);
      pr[j] = $urandom_range(ROWS_DEF - 1);
      pc[j] = $urandom_range(COLS_DEF - 1);
      pb[j] = $urandom_range(1023);
    end
    for (k = 0; k < count; k++) begin
      j = $urandom_range(5);
      c = $urandom_range(99);
      if (c < 68) begin
        if ($urandom_range(19) == 0) push(OP_HIT, ps[j], pr[j], pc[j], $urandom_range(1023));
        else push(OP_HIT, ps[j], pr[j], pc[j],
                  ((pb[j] + $urandom_range(8) - 4) < 0) ? 0 :
                  ((pb[j] + $urandom_range(8) - 4) > 1023) ? 1023 :
                  pb[j] + $urandom_range(8) - 4);
      end else if (c < 85) begin
        push(OP_READ, ps[j], pr[j], pc[j], $urandom_range(1023));
      end else begin
        push($urandom_range(1), $urandom_range(7), $urandom_range(127), $urandom_range(127),
             $urandom_range(1023));
      end
    end
  endtask

  initial begin
    int ph;
    errors = 0;
    n_results = 0;
    n_runaway = 0;
    n_accepted = 0;
    pressure_go = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    en_r = 6'd0;
    kmul_r = 8'd96;
    eps_r = 16'd66;
    mind_r = 10'd2;
    minc_r = 8'd5;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_dat = '0;
    in_if.valid = 1'b0;
    in_if.operation = 1'b0;
    in_if.sector = '0;
    in_if.pad_row = '0;
    in_if.pad_col = '0;
    in_if.charge = '0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: defaults, then edges of every field
    push(OP_HIT, 0, 0, 0, 5);
    push(OP_READ, 0, 0, 0, 0);
    drain();
    set_all(6'h3F, 8'd96, 16'd66, 10'd2, 8'd5);
    push(OP_READ, 5, 89, 91, 0);
    push(OP_HIT, 0, 0, 0, 0);
    push(OP_READ, 0, 0, 0, 0);
    push(OP_HIT, 0, 0, 0, 1023);
    push(OP_READ, 0, 0, 0, 1023);
    push(OP_HIT, 5, 89, 91, 1023);
    push(OP_HIT, 5, 89, 91, 1000);
    push(OP_READ, 5, 89, 91, 0);
    push(OP_HIT, 1, 90, 0, 7);
    push(OP_HIT, 1, 0, 92, 7);
    push(OP_READ, 2, 127, 127, 0);
    push(OP_HIT, 6, 3, 3, 9);
    push(OP_READ, 7, 3, 3, 9);
    for (int k = 0; k < 7; k++) push(OP_HIT, 2, 10, 10, 100 + k % 2);
    push(OP_HIT, 2, 10, 10, 900);
    push(OP_READ, 2, 10, 10, 0);
    drain();
    set_all(6'h00, 8'd96, 16'd66, 10'd2, 8'd5);
    push(OP_HIT, 2, 10, 10, 100);
    push(OP_READ, 2, 10, 10, 0);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(6'h3F, 8'd96, 16'd66, 10'd2, 8'd5);
        1: set_all(6'h2A, 8'd0, 16'd0, 10'd0, 8'd0);
        2: set_all(6'h15, 8'd255, 16'hFFFF, 10'd1023, 8'd255);
        3: set_all(6'h3F, 8'd16, 16'd1000, 10'd1, 8'd2);
        4: set_all(6'h3F, 8'd40, 16'd66, 10'd3, 8'd1);
        default: set_all(6'h3F, 8'd8, 16'd0, 10'd0, 8'd3);
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 83; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 83; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      random_phase(200);
      if (ph == 4) pressure_go <= 1'b1;
      drain();
    end

    $display("covered %0d results: %0d accepted hits, %0d runaway rejections,", n_results,
             n_accepted, n_runaway);
    $display("over six register settings and four idle/stall mixes");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pmv_pkg.sv
rtl/pmv_if.sv
rtl/pmv_ram.sv
rtl/pmv_divsqrt.sv
rtl/pad_pedestal_mean_variance_core.sv
bench/tb_top.sv
